// File: rtl/pls_pkg.sv
// Shared types and constants for the per-link / per-channel statistics block.
// No dependencies; imported by every module of the block but pls_div.
package pls_pkg;

	localparam int LINKS_DEF    = 64;
	localparam int CHANNELS_DEF = 4096;
	localparam int LINK_WORDS   = 22;  // stored words per link record
	localparam int LINK_OUT     = 21;  // words emitted by a link dump
	localparam int CHAN_WORDS   = 6;   // stored and emitted words per channel
	localparam int QDEPTH       = 4;   // front-to-back item queue

	localparam logic [1:0] OP_HDR   = 2'd0;
	localparam logic [1:0] OP_PRIM  = 2'd1;
	localparam logic [1:0] OP_DLINK = 2'd2;
	localparam logic [1:0] OP_DCHAN = 2'd3;

	localparam logic [1:0] REG_TPU   = 2'd0;
	localparam logic [1:0] REG_EPOCH = 2'd1;

	// link record word numbers
	localparam logic [4:0] W_NSETS   = 5'd0;
	localparam logic [4:0] W_NTPS    = 5'd1;
	localparam logic [4:0] W_NSKIP   = 5'd2;
	localparam logic [4:0] W_NCHAN   = 5'd3;
	localparam logic [4:0] W_NBYTES  = 5'd4;
	localparam logic [4:0] W_TOTADC  = 5'd5;
	localparam logic [4:0] W_ADCSUM  = 5'd6;
	localparam logic [4:0] W_TSTART  = 5'd7;
	localparam logic [4:0] W_TSSPAN  = 5'd8;
	localparam logic [4:0] W_TCREAT  = 5'd9;
	localparam logic [4:0] W_TCSPAN  = 5'd10;
	localparam logic [4:0] W_TRECV   = 5'd11;
	localparam logic [4:0] W_TRSPAN  = 5'd12;
	localparam logic [4:0] W_DTRSUM  = 5'd13;
	localparam logic [4:0] W_DTRSQ   = 5'd14;
	localparam logic [4:0] W_DTRMIN  = 5'd15;
	localparam logic [4:0] W_DTRMAX  = 5'd16;
	localparam logic [4:0] W_DTCSUM  = 5'd17;
	localparam logic [4:0] W_DTCSQ   = 5'd18;
	localparam logic [4:0] W_DTCMIN  = 5'd19;
	localparam logic [4:0] W_DTCMAX  = 5'd20;
	localparam logic [4:0] W_LASTSEQ = 5'd21;

	// channel record word numbers
	localparam logic [2:0] C_TSTART = 3'd0;
	localparam logic [2:0] C_TSSPAN = 3'd1;
	localparam logic [2:0] C_NTPS   = 3'd2;
	localparam logic [2:0] C_SPAN   = 3'd3;
	localparam logic [2:0] C_ADC    = 3'd4;
	localparam logic [2:0] C_PEAK   = 3'd5;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] entry_index;
		logic [31:0] sequence_number;
		logic [62:0] data_time_ticks;
		logic [52:0] created_us;
		logic [52:0] received_us;
		logic [31:0] set_total_adc;
		logic [15:0] set_bytes;
		logic [15:0] primitive_count;
		logic [31:0] span_ticks;
		logic [31:0] prim_adc_sum;
		logic [15:0] prim_adc_peak;
	} pls_item_t;

	typedef struct packed {
		logic [9:0]  tpu;
		logic [52:0] epoch;
	} pls_cfg_t;

endpackage

// File: rtl/per_link_channel_statistics.sv
// Per-link / per-channel statistics. A header or primitive goes through the tick
// divider, then a read-modify-write of each record word; a channel dump reads out
// its record, a link dump first sweeps the seen map, one row a cycle. After reset a
// clearing pass zeroes all memories; no item is taken then. Config registers reset
// to ticks_per_microsecond=1, epoch_offset_us=0.
module per_link_channel_statistics #(
	parameter int LINKS    = pls_pkg::LINKS_DEF,
	parameter int CHANNELS = pls_pkg::CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [52:0]        cfg_data,
	// input item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [11:0]        entry_index,
	input  logic [31:0]        sequence_number,
	input  logic [62:0]        data_time_ticks,
	input  logic [52:0]        created_us,
	input  logic [52:0]        received_us,
	input  logic [31:0]        set_total_adc,
	input  logic [15:0]        set_bytes,
	input  logic [15:0]        primitive_count,
	input  logic [31:0]        span_ticks,
	input  logic [31:0]        prim_adc_sum,
	input  logic [15:0]        prim_adc_peak,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         stat_index,
	output logic signed [63:0] stat_value,
	output logic               entry_present,
	output logic               last_word
);
	import pls_pkg::*;

	// Front takes a transfer into a short queue and holds config; back pulls
	// one item at a time and runs it against the record memories. A dump word
	// waiting in the output register does not block the front.
	pls_item_t in_item;
	pls_item_t q_item;
	pls_cfg_t  cfg;
	logic      q_valid, q_pop, clearing;

	assign in_item = '{
		opcode:          opcode,
		entry_index:     entry_index,
		sequence_number: sequence_number,
		data_time_ticks: data_time_ticks,
		created_us:      created_us,
		received_us:     received_us,
		set_total_adc:   set_total_adc,
		set_bytes:       set_bytes,
		primitive_count: primitive_count,
		span_ticks:      span_ticks,
		prim_adc_sum:    prim_adc_sum,
		prim_adc_peak:   prim_adc_peak
	};

	pls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// Back: divider for tick conversion, shared 32x32 multiplier for the
	// latency squares, then word-by-word record update or dump.
	pls_back #(
		.LINKS    (LINKS),
		.CHANNELS (CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.stat_index    (stat_index),
		.stat_value    (stat_value),
		.entry_present (entry_present),
		.last_word     (last_word)
	);

endmodule

// File: rtl/pls_front.sv
// Front end: configuration registers and the input item queue.
// Depends on pls_pkg.
module pls_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pls_pkg::pls_item_t  in_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [52:0]         cfg_data,
	output pls_pkg::pls_cfg_t   cfg,
	input  logic                clearing,
	output logic                q_valid,
	output pls_pkg::pls_item_t  q_item,
	input  logic                q_pop
);
	import pls_pkg::*;

	localparam int QW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int NW = $clog2(QDEPTH + 1);

	pls_item_t        fifo_q [QDEPTH];
	logic [QW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    cnt_q;
	pls_cfg_t         cfg_q;
	logic             push, pop;

	assign in_stall  = clearing || (int'(cnt_q) == QDEPTH);
	assign push      = in_valid && !in_stall;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_item    = fifo_q[rd_q];
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (int'(wr_q) == QDEPTH - 1) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (int'(rd_q) == QDEPTH - 1) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tpu   <= 10'd1;
			cfg_q.epoch <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TPU:   cfg_q.tpu   <= cfg_data[9:0];
				REG_EPOCH: cfg_q.epoch <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/pls_div.sv
// Restoring divider, one quotient bit per cycle, 63-bit by 10-bit.
// Depends on nothing; a zero divisor divides as one.
module pls_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [62:0] dividend,
	input  logic [9:0]  divisor,
	output logic        done,
	output logic [62:0] quotient
);
	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [9:0]  rem_q, d_q;
	logic [62:0] num_q;
	logic [10:0] sh, diff;
	logic        ge;

	assign sh       = {rem_q, num_q[62]};
	assign ge       = (sh >= {1'b0, d_q});
	assign diff     = sh - {1'b0, d_q};
	assign done     = done_q;
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= 10'd1;
			num_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= (divisor == '0) ? 10'd1 : divisor;
			num_q  <= dividend;
		end else if (busy_q) begin
			num_q  <= {num_q[61:0], ge};
			rem_q  <= ge ? diff[9:0] : sh[9:0];
			cnt_q  <= cnt_q + 6'd1;
			if (cnt_q == 6'd62) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

// File: rtl/pls_back.sv
// Back end: record sequencer, link/channel/seen memories, output register.
// Depends on pls_pkg and pls_div.
module pls_back #(
	parameter int LINKS    = pls_pkg::LINKS_DEF,
	parameter int CHANNELS = pls_pkg::CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pls_pkg::pls_cfg_t  cfg,
	input  logic               q_valid,
	input  pls_pkg::pls_item_t q_item,
	output logic               q_pop,
	output logic               clearing,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         stat_index,
	output logic signed [63:0] stat_value,
	output logic               entry_present,
	output logic               last_word
);
	import pls_pkg::*;

	localparam int LW    = (LINKS > 1) ? $clog2(LINKS) : 1;
	localparam int CW    = $clog2(CHANNELS);
	localparam int LAW   = $clog2(LINKS * LINK_WORDS);
	localparam int CAW   = $clog2(CHANNELS * CHAN_WORDS);
	localparam int CLR_N = (LINKS * LINK_WORDS > CHANNELS * CHAN_WORDS) ?
	                       LINKS * LINK_WORDS : CHANNELS * CHAN_WORDS;
	localparam int CLRW  = $clog2(CLR_N);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_LAT   = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_RD    = 4'd5;
	localparam logic [3:0] ST_WB    = 4'd6;
	localparam logic [3:0] ST_SWEEP = 4'd7;
	localparam logic [3:0] ST_ZERO  = 4'd8;

	function automatic logic [4:0] hdr_word(input logic [4:0] s);
		if (s == 5'd0)
			return W_NSETS;
		if (s == 5'd1)
			return W_LASTSEQ;
		return s - 5'd1;
	endfunction

	function automatic logic [2:0] chan_word(input logic [2:0] s);
		logic [2:0] w;
		unique case (s)
			3'd0:    w = C_NTPS;
			3'd1:    w = C_TSTART;
			3'd2:    w = C_TSSPAN;
			3'd3:    w = C_SPAN;
			3'd4:    w = C_ADC;
			3'd5:    w = C_PEAK;
			default: w = C_NTPS;
		endcase
		return w;
	endfunction

	function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

	// memories
	logic [63:0]    lmem [LINKS * LINK_WORDS];
	logic [63:0]    cmem [CHANNELS * CHAN_WORDS];
	logic [LINKS-1:0] smem [CHANNELS];
	logic [63:0]    lm_rd, cm_rd;
	logic [LINKS-1:0] sm_rd;

	logic           lm_re, lm_we, cm_re, cm_we, sm_re, sm_we;
	logic [LAW-1:0] lm_addr;
	logic [CAW-1:0] cm_addr;
	logic [CW-1:0]  sm_ra, sm_wa;
	logic [63:0]    lm_wd, cm_wd;
	logic [LINKS-1:0] sm_wd;

	// control and datapath registers
	logic [3:0]     state_q;
	pls_item_t      it_q;
	logic [4:0]     step_q;
	logic [2:0]     mstep_q;
	logic           first_q, skip_q, present_q;
	logic [63:0]    base_q, tstart_q, dr_q, dc_q, sqr_q, sqc_q, prod_q, cdt_q;
	logic [LW-1:0]  cl_q;
	logic [CW:0]    sw_q, cnt_q;
	logic [CLRW-1:0] clr_q;

	logic           out_valid_q, out_pres_q, out_last_q;
	logic [4:0]     out_idx_q;
	logic [63:0]    out_val_q;

	// divider
	logic           div_start, div_done;
	logic [62:0]    div_quo, div_num;

	pls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (cfg.tpu),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic [LW-1:0]  it_lnk, lsel;
	logic [CW-1:0]  it_ch;
	logic [4:0]     hw, lword;
	logic [2:0]     cwd, cword;
	logic           hf, cf, hskip, slot_free, go, emit;
	logic [63:0]    hnew, cnew, seq64, rcv64, crt64, e_val;
	logic [4:0]     e_idx, zn;
	logic           e_pres, e_last;
	logic [31:0]    mul_a, mul_b;
	logic           link_ok, chan_ok;

	assign it_lnk    = it_q.entry_index[LW-1:0];
	assign it_ch     = CW'(it_q.entry_index);
	assign hw        = hdr_word(step_q);
	assign cwd       = chan_word(step_q[2:0]);
	assign seq64     = {32'd0, it_q.sequence_number};
	assign rcv64     = {11'd0, it_q.received_us};
	assign crt64     = {11'd0, it_q.created_us};
	assign slot_free = !out_valid_q || !out_stall;
	assign clearing  = (state_q == ST_CLR);
	assign link_ok   = int'(q_item.entry_index) < LINKS;
	assign chan_ok   = int'(q_item.entry_index) < CHANNELS;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign div_start = q_pop && (((q_item.opcode == OP_HDR) && link_ok) ||
	                             ((q_item.opcode == OP_PRIM) && chan_ok));
	assign div_num   = (q_item.opcode == OP_HDR) ? q_item.data_time_ticks :
	                   {31'd0, q_item.span_ticks};
	assign zn        = (it_q.opcode == OP_DLINK) ? 5'(LINK_OUT) : 5'(CHAN_WORDS);

	// record word selection
	always_comb begin
		if (it_q.opcode == OP_PRIM) begin
			lsel  = cl_q;
			lword = W_ADCSUM;
		end else if (it_q.opcode == OP_HDR) begin
			lsel  = it_lnk;
			lword = hw;
		end else begin
			lsel  = it_lnk;
			lword = step_q;
		end
		if (it_q.opcode == OP_PRIM)
			cword = cwd;
		else
			cword = (step_q == 5'd0) ? C_NTPS : 3'(step_q - 5'd1);
	end

	assign lm_addr = clearing ? LAW'(clr_q) :
	                 LAW'(int'(lsel) * LINK_WORDS + int'(lword));
	assign cm_addr = clearing ? CAW'(clr_q) :
	                 CAW'(int'(it_ch) * CHAN_WORDS + int'(cword));
	assign sm_ra   = (state_q == ST_SWEEP) ? CW'(sw_q) : it_ch;
	assign sm_wa   = clearing ? CW'(clr_q) :
	                 (state_q == ST_SWEEP) ? CW'(sw_q - 1'b1) : it_ch;

	// header word update
	always_comb begin
		hf    = (step_q == 5'd0) ? (lm_rd == '0) : first_q;
		hskip = !hf && !((lm_rd == seq64) || (lm_rd + 64'd1 == seq64));
		unique case (hw)
			W_NSETS:   hnew = lm_rd + 64'd1;
			W_NTPS:    hnew = lm_rd + {48'd0, it_q.primitive_count};
			W_NSKIP:   hnew = lm_rd + {63'd0, skip_q};
			W_NBYTES:  hnew = lm_rd + {48'd0, it_q.set_bytes};
			W_TOTADC:  hnew = lm_rd + {32'd0, it_q.set_total_adc};
			W_TSTART:  hnew = hf ? tstart_q : lm_rd;
			W_TSSPAN:  hnew = tstart_q - base_q;
			W_TCREAT:  hnew = hf ? crt64 : lm_rd;
			W_TCSPAN:  hnew = crt64 - base_q;
			W_TRECV:   hnew = hf ? rcv64 : lm_rd;
			W_TRSPAN:  hnew = rcv64 - base_q;
			W_DTRSUM:  hnew = lm_rd + dr_q;
			W_DTRSQ:   hnew = lm_rd + sqr_q;
			W_DTRMIN:  hnew = (hf || slt(dr_q, lm_rd)) ? dr_q : lm_rd;
			W_DTRMAX:  hnew = (hf || slt(lm_rd, dr_q)) ? dr_q : lm_rd;
			W_DTCSUM:  hnew = lm_rd + dc_q;
			W_DTCSQ:   hnew = lm_rd + sqc_q;
			W_DTCMIN:  hnew = (hf || slt(dc_q, lm_rd)) ? dc_q : lm_rd;
			W_DTCMAX:  hnew = (hf || slt(lm_rd, dc_q)) ? dc_q : lm_rd;
			W_LASTSEQ: hnew = seq64;
			default:   hnew = lm_rd;
		endcase
	end

	// channel word update for a primitive
	always_comb begin
		cf = (step_q == 5'd0) ? (cm_rd == '0) : first_q;
		unique case (cwd)
			C_NTPS:   cnew = cm_rd + 64'd1;
			C_TSTART: cnew = cf ? cdt_q : cm_rd;
			C_TSSPAN: cnew = cdt_q - base_q;
			C_SPAN:   cnew = cm_rd + {1'b0, div_quo};
			C_ADC:    cnew = cm_rd + {32'd0, it_q.prim_adc_sum};
			C_PEAK:   cnew = cm_rd + {48'd0, it_q.prim_adc_peak};
			default:  cnew = cm_rd;
		endcase
	end

	// memory port and output control
	always_comb begin
		lm_re  = 1'b0; lm_we = 1'b0; lm_wd = '0;
		cm_re  = 1'b0; cm_we = 1'b0; cm_wd = '0;
		sm_re  = 1'b0; sm_we = 1'b0; sm_wd = '0;
		go     = 1'b0;
		emit   = 1'b0;
		e_idx  = step_q;
		e_val  = '0;
		e_pres = 1'b0;
		e_last = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				lm_we = int'(clr_q) < LINKS * LINK_WORDS;
				cm_we = int'(clr_q) < CHANNELS * CHAN_WORDS;
				sm_we = int'(clr_q) < CHANNELS;
			end
			ST_RD: begin
				unique case (it_q.opcode)
					OP_HDR, OP_DLINK: lm_re = 1'b1;
					OP_DCHAN:         cm_re = 1'b1;
					OP_PRIM: begin
						cm_re = (step_q < 5'd6);
						lm_re = (step_q == 5'd6);
						sm_re = (step_q == 5'd7);
					end
					default: ;
				endcase
			end
			ST_SWEEP: begin
				sm_re = int'(sw_q) < CHANNELS;
				sm_we = (sw_q != '0);
				sm_wd = sm_rd & ~(LINKS'(1) << it_lnk);
			end
			ST_WB: begin
				unique case (it_q.opcode)
					OP_HDR: begin
						go    = 1'b1;
						lm_we = 1'b1;
						lm_wd = hnew;
					end
					OP_PRIM: begin
						go = 1'b1;
						if (step_q < 5'd6) begin
							cm_we = 1'b1;
							cm_wd = cnew;
						end else if (step_q == 5'd6) begin
							lm_we = 1'b1;
							lm_wd = lm_rd + {32'd0, it_q.prim_adc_sum};
						end else begin
							sm_we = 1'b1;
							sm_wd = sm_rd | (LINKS'(1) << cl_q);
						end
					end
					OP_DLINK: begin
						emit   = (step_q < 5'(LINK_OUT));
						go     = !emit || slot_free;
						lm_we  = go;
						e_val  = (step_q == W_NCHAN) ? 64'(cnt_q) : lm_rd;
						e_pres = (step_q == 5'd0) ? (lm_rd != '0) : present_q;
						e_last = (step_q == 5'(LINK_OUT - 1));
					end
					OP_DCHAN: begin
						emit   = (step_q != 5'd0);
						go     = !emit || slot_free;
						cm_we  = emit && slot_free;
						e_idx  = step_q - 5'd1;
						e_val  = cm_rd;
						e_pres = present_q;
						e_last = (step_q == 5'(CHAN_WORDS));
					end
					default: ;
				endcase
			end
			ST_ZERO: begin
				emit   = 1'b1;
				e_last = (step_q == zn - 5'd1);
			end
			default: ;
		endcase
	end

	// square operand select for the shared 32x32 multiplier
	always_comb begin
		unique case (mstep_q)
			3'd0:    begin mul_a = dr_q[31:0];  mul_b = dr_q[31:0]; end
			3'd1:    begin mul_a = dr_q[63:32]; mul_b = dr_q[31:0]; end
			3'd2:    begin mul_a = dc_q[31:0];  mul_b = dc_q[31:0]; end
			3'd3:    begin mul_a = dc_q[63:32]; mul_b = dc_q[31:0]; end
			default: begin mul_a = '0;          mul_b = '0;         end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lm_we)
			lmem[lm_addr] <= lm_wd;
		if (lm_re)
			lm_rd <= lmem[lm_addr];
		if (cm_we)
			cmem[cm_addr] <= cm_wd;
		if (cm_re)
			cm_rd <= cmem[cm_addr];
		if (sm_we)
			smem[sm_wa] <= sm_wd;
		if (sm_re)
			sm_rd <= smem[sm_ra];
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			it_q      <= '0;
			step_q    <= '0;
			mstep_q   <= '0;
			first_q   <= 1'b0;
			skip_q    <= 1'b0;
			present_q <= 1'b0;
			base_q    <= '0;
			tstart_q  <= '0;
			dr_q      <= '0;
			dc_q      <= '0;
			sqr_q     <= '0;
			sqc_q     <= '0;
			cdt_q     <= '0;
			cl_q      <= '0;
			sw_q      <= '0;
			cnt_q     <= '0;
			clr_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == CLR_N - 1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) begin
						it_q   <= q_item;
						step_q <= '0;
						sw_q   <= '0;
						cnt_q  <= '0;
						unique case (q_item.opcode)
							OP_HDR:   if (link_ok) state_q <= ST_DIV;
							OP_PRIM:  if (chan_ok) state_q <= ST_DIV;
							OP_DLINK: state_q <= link_ok ? ST_SWEEP : ST_ZERO;
							OP_DCHAN: state_q <= chan_ok ? ST_RD : ST_ZERO;
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						tstart_q <= {1'b0, div_quo} - {11'd0, cfg.epoch};
						state_q  <= (it_q.opcode == OP_HDR) ? ST_LAT : ST_RD;
					end
				end
				ST_LAT: begin
					dr_q    <= rcv64 - tstart_q;
					dc_q    <= rcv64 - crt64;
					mstep_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 3'd1;
					unique case (mstep_q)
						3'd1:    sqr_q <= prod_q;
						3'd2:    sqr_q <= sqr_q + {prod_q[30:0], 33'd0};
						3'd3:    sqc_q <= prod_q;
						3'd4: begin
							sqc_q   <= sqc_q + {prod_q[30:0], 33'd0};
							state_q <= ST_RD;
						end
						default: ;
					endcase
				end
				ST_RD: state_q <= ST_WB;
				ST_SWEEP: begin
					if ((sw_q != '0) && sm_rd[it_lnk])
						cnt_q <= cnt_q + 1'b1;
					if (int'(sw_q) == CHANNELS) begin
						step_q  <= '0;
						state_q <= ST_RD;
					end else begin
						sw_q <= sw_q + 1'b1;
					end
				end
				ST_WB: begin
					unique case (it_q.opcode)
						OP_HDR: begin
							if (step_q == 5'd0)
								first_q <= hf;
							if (hw == W_LASTSEQ)
								skip_q <= hskip;
							if (hw == W_TSTART || hw == W_TCREAT || hw == W_TRECV)
								base_q <= hnew;
						end
						OP_PRIM: begin
							if (step_q == 5'd0)
								first_q <= cf;
							if (step_q < 5'd6 && cwd == C_TSTART)
								base_q <= cnew;
						end
						OP_DLINK: if (step_q == 5'd0) present_q <= (lm_rd != '0);
						OP_DCHAN: if (step_q == 5'd0) present_q <= (cm_rd != '0);
						default: ;
					endcase
					if (go) begin
						if ((it_q.opcode == OP_HDR && step_q == 5'(LINK_WORDS - 1)) ||
						    (it_q.opcode == OP_PRIM && step_q == 5'd7) ||
						    (it_q.opcode == OP_DLINK && step_q == 5'(LINK_WORDS - 1)) ||
						    (it_q.opcode == OP_DCHAN && step_q == 5'(CHAN_WORDS))) begin
							state_q <= ST_IDLE;
							if (it_q.opcode == OP_HDR) begin
								cl_q  <= it_lnk;
								cdt_q <= tstart_q;
							end
						end else begin
							step_q  <= step_q + 5'd1;
							state_q <= ST_RD;
						end
					end
				end
				ST_ZERO: begin
					if (slot_free) begin
						if (e_last)
							state_q <= ST_IDLE;
						else
							step_q <= step_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_val_q   <= '0;
			out_pres_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (emit && slot_free) begin
			out_valid_q <= 1'b1;
			out_idx_q   <= e_idx;
			out_val_q   <= e_val;
			out_pres_q  <= e_pres;
			out_last_q  <= e_last;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat_index    = out_idx_q;
	assign stat_value    = out_val_q;
	assign entry_present = out_pres_q;
	assign last_word     = out_last_q;

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |->
		(out_idx_q == 5'(LINK_OUT - 1)) || (out_idx_q == 5'(CHAN_WORDS - 1)))
		else $error("last word at unexpected index");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop)
		else $error("item taken during clearing pass");

	a_dump_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) && emit && !slot_free |=>
		(state_q == ST_WB) && $stable(step_q))
		else $error("dump advanced while output slot busy");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for per_link_channel_statistics: set headers and primitives update
// an in-bench statistics model; link/channel dumps are checked word by word against it.
// Depends on rtl/pls_pkg.sv and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
	import pls_pkg::*;

	localparam int NLINK = LINKS_DEF;
	localparam int NCHAN = CHANNELS_DEF;
	// worst case per item: link dump sweeps every channel row, plus a long receiver stall
	localparam int WATCHDOG_LIMIT = 40000 + 8 * NCHAN;
	// queue plus the item in the back, all headers, with margin
	localparam int SETTLE_CYCLES = 1000;

	typedef struct packed {
		logic [4:0]  idx;
		logic [63:0] val;
		logic        present;
		logic        last;
	} stat_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [52:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	pls_item_t   item_d = '0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  stat_index;
	logic signed [63:0] stat_value;
	logic        entry_present;
	logic        last_word;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	per_link_channel_statistics uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(item_d.opcode), .entry_index(item_d.entry_index),
		.sequence_number(item_d.sequence_number), .data_time_ticks(item_d.data_time_ticks),
		.created_us(item_d.created_us), .received_us(item_d.received_us),
		.set_total_adc(item_d.set_total_adc), .set_bytes(item_d.set_bytes),
		.primitive_count(item_d.primitive_count), .span_ticks(item_d.span_ticks),
		.prim_adc_sum(item_d.prim_adc_sum), .prim_adc_peak(item_d.prim_adc_peak),
		.out_valid(out_valid), .out_stall(out_stall), .stat_index(stat_index),
		.stat_value(stat_value), .entry_present(entry_present), .last_word(last_word)
	);

	// ---------------- statistics model ----------------
	logic [9:0]  tpu_m;
	logic [52:0] epoch_m;
	logic [63:0] link_st [NLINK][LINK_WORDS];
	logic [63:0] chan_st [NCHAN][CHAN_WORDS];
	logic [NLINK-1:0] seen_by [NCHAN];
	int unsigned cur_link;
	logic [63:0] cur_time;

	stat_word_t pending_words[$];

	function automatic logic [63:0] div_ticks(logic [63:0] t);
		return t / ((tpu_m == 0) ? 64'd1 : 64'(tpu_m));
	endfunction

	function automatic bit s_lt(logic [63:0] a, logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

	task automatic track_lat(int unsigned lk, int base, logic [63:0] d, bit first);
		link_st[lk][base]     += d;
		link_st[lk][base + 1] += d * d;
		if (first || s_lt(d, link_st[lk][base + 2])) link_st[lk][base + 2] = d;
		if (first || s_lt(link_st[lk][base + 3], d)) link_st[lk][base + 3] = d;
	endtask

	task automatic push_record(logic [63:0] w[], bit present);
		stat_word_t s;
		for (int k = 0; k < w.size(); k++) begin
			s.idx = 5'(k);
			s.val = w[k];
			s.present = present;
			s.last = (k == w.size() - 1);
			pending_words.push_back(s);
		end
	endtask

	task automatic model_reset();
		tpu_m = 10'd1;
		epoch_m = '0;
		foreach (link_st[i, j]) link_st[i][j] = '0;
		foreach (chan_st[i, j]) chan_st[i][j] = '0;
		foreach (seen_by[i]) seen_by[i] = '0;
		cur_link = 0;
		cur_time = '0;
	endtask

	// accepted item -> updated statistics and any dumped words
	task automatic update_stats(pls_item_t it);
		logic [63:0] w[];
		logic [63:0] ts, seq, cr, rv, cnt, adc;
		int unsigned lk, ix;
		bit first, present;
		ix = 32'(it.entry_index);
		case (it.opcode)
			OP_HDR: begin
				if (ix >= NLINK) return;
				ts = div_ticks(64'(it.data_time_ticks)) - 64'(epoch_m);
				seq = 64'(it.sequence_number);
				cr = 64'(it.created_us);
				rv = 64'(it.received_us);
				link_st[ix][W_TOTADC] += 64'(it.set_total_adc);
				link_st[ix][W_NBYTES] += 64'(it.set_bytes);
				first = (link_st[ix][W_NSETS] == 0);
				if (first) begin
					link_st[ix][W_LASTSEQ] = seq;
					link_st[ix][W_TSTART] = ts;
					link_st[ix][W_TCREAT] = cr;
					link_st[ix][W_TRECV] = rv;
				end
				link_st[ix][W_TSSPAN] = ts - link_st[ix][W_TSTART];
				link_st[ix][W_TCSPAN] = cr - link_st[ix][W_TCREAT];
				link_st[ix][W_TRSPAN] = rv - link_st[ix][W_TRECV];
				// a backward step wraps to a huge difference and counts as a skip
				if (seq - link_st[ix][W_LASTSEQ] > 64'd1) link_st[ix][W_NSKIP] += 64'd1;
				link_st[ix][W_LASTSEQ] = seq;
				track_lat(ix, W_DTRSUM, rv - ts, first);
				track_lat(ix, W_DTCSUM, rv - cr, first);
				link_st[ix][W_NSETS] += 64'd1;
				link_st[ix][W_NTPS] += 64'(it.primitive_count);
				cur_link = ix;
				cur_time = ts;
			end
			OP_PRIM: begin
				if (ix >= NCHAN) return;
				lk = cur_link % NLINK;
				adc = 64'(it.prim_adc_sum);
				seen_by[ix][lk] = 1'b1;
				link_st[lk][W_ADCSUM] += adc;
				if (chan_st[ix][C_NTPS] == 0) chan_st[ix][C_TSTART] = cur_time;
				chan_st[ix][C_TSSPAN] = cur_time - chan_st[ix][C_TSTART];
				chan_st[ix][C_NTPS] += 64'd1;
				chan_st[ix][C_SPAN] += div_ticks(64'(it.span_ticks));
				chan_st[ix][C_ADC] += adc;
				chan_st[ix][C_PEAK] += 64'(it.prim_adc_peak);
			end
			OP_DLINK: begin
				w = new[LINK_OUT];
				foreach (w[k]) w[k] = '0;
				if (ix >= NLINK) begin
					push_record(w, 1'b0);
					return;
				end
				cnt = '0;
				for (int ch = 0; ch < NCHAN; ch++) begin
					if (seen_by[ch][ix]) cnt++;
					seen_by[ch][ix] = 1'b0;
				end
				foreach (w[k]) w[k] = link_st[ix][k];
				w[W_NCHAN] = cnt;
				present = (link_st[ix][W_NSETS] != 0);
				for (int k = 0; k < LINK_WORDS; k++) link_st[ix][k] = '0;
				push_record(w, present);
			end
			default: begin
				w = new[CHAN_WORDS];
				foreach (w[k]) w[k] = '0;
				if (ix >= NCHAN) begin
					push_record(w, 1'b0);
					return;
				end
				foreach (w[k]) w[k] = chan_st[ix][k];
				present = (chan_st[ix][C_NTPS] != 0);
				// seen bits survive a channel clear
				for (int k = 0; k < CHAN_WORDS; k++) chan_st[ix][k] = '0;
				push_record(w, present);
			end
		endcase
	endtask

	// ---------------- checking ----------------
	int fail_count = 0;
	int words_seen = 0;
	int items_sent = 0;
	int idle_cycles = 0;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		fail_count++;
		$display("MISMATCH t=%0t %s: got %h expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		stat_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected transfer, stat_index", 64'(stat_index), 64'd0);
			end else begin
				e = pending_words.pop_front();
				if (stat_index !== e.idx)
					report_mismatch("stat_index", 64'(stat_index), 64'(e.idx));
				if (stat_value !== e.val)
					report_mismatch($sformatf("stat_value[%0d]", e.idx), stat_value, e.val);
				if (entry_present !== e.present)
					report_mismatch("entry_present", 64'(entry_present), 64'(e.present));
				if (last_word !== e.last)
					report_mismatch("last_word", 64'(last_word), 64'(e.last));
			end
		end
	end

	// watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------- receiver ----------------
	int stall_pct = 0;
	int hold_off = 0;  // long forced stall, counted down here

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ---------------- sender ----------------
	int send_idle_pct = 0;

	// one transfer: random gaps before, then hold until accepted; valid stays up
	// so the next transfer can follow directly, wait_idle drops it
	task automatic send_item(pls_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		item_d <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		update_stats(it);
		items_sent++;
	endtask

	task automatic write_reg(logic [1:0] ri, logic [52:0] val);
		cfg_index <= ri;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (ri == REG_TPU) tpu_m = val[9:0];
		else epoch_m = val;
		@(posedge clk);
	endtask

	// drain expectations, then let in-flight headers/primitives settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic pls_item_t rand_item(logic [1:0] op, int unsigned ix);
		pls_item_t it;
		it.opcode = op;
		it.entry_index = 12'(ix);
		it.sequence_number = $urandom;
		it.data_time_ticks = 63'({$urandom, $urandom});
		it.created_us = 53'({$urandom, $urandom});
		it.received_us = 53'({$urandom, $urandom});
		it.set_total_adc = $urandom;
		it.set_bytes = 16'($urandom);
		it.primitive_count = 16'($urandom);
		it.span_ticks = $urandom;
		it.prim_adc_sum = $urandom;
		it.prim_adc_peak = 16'($urandom);
		return it;
	endfunction

	// a plausible set: header on a small link, some primitives, mostly in-order sequence
	logic [31:0] next_seq [NLINK];

	task automatic send_set();
		pls_item_t h, p;
		int unsigned lk, n;
		lk = $urandom_range(7);
		h = rand_item(OP_HDR, lk);
		h.sequence_number = ($urandom_range(9) == 0) ? $urandom : next_seq[lk];
		next_seq[lk] = h.sequence_number + 32'd1;
		h.data_time_ticks = 63'($urandom_range(1000000)) + 63'(1000000) * 63'(lk);
		h.created_us = 53'(h.data_time_ticks) + 53'($urandom_range(500));
		h.received_us = h.created_us + 53'($urandom_range(500));
		send_item(h);
		n = $urandom_range(4);
		for (int i = 0; i < n; i++) begin
			p = rand_item(OP_PRIM, $urandom_range(31));
			send_item(p);
		end
	endtask

	task automatic random_phase(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 55) send_set();
			else if (r < 70) send_item(rand_item(OP_DCHAN, $urandom_range(31)));
			else if (r < 78) send_item(rand_item(OP_DLINK, $urandom_range(7)));
			else if (r < 90) send_item(rand_item(2'($urandom_range(3)), $urandom_range(4095)));
			else send_item(rand_item(2'($urandom_range(1)), $urandom_range(NLINK - 1)));
		end
	endtask

	// directed rows: item plus optional literal expectation of the first dump word
	typedef struct {
		pls_item_t it;
		bit        has_lit;
		logic [63:0] lit0;
		bit        lit_present;
	} dir_row_t;

	dir_row_t dir_tab[$];

	function automatic pls_item_t mk(logic [1:0] op, logic [11:0] ix);
		pls_item_t it;
		it = '0;
		it.opcode = op;
		it.entry_index = ix;
		return it;
	endfunction

	function automatic dir_row_t row(pls_item_t it, bit has_lit = 0, logic [63:0] v = 0,
			bit pr = 0);
		dir_row_t d;
		d.it = it;
		d.has_lit = has_lit;
		d.lit0 = v;
		d.lit_present = pr;
		return d;
	endfunction

	initial begin
		pls_item_t t;
		stat_word_t e;
		model_reset();
		foreach (next_seq[i]) next_seq[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty entries right after reset dump all zeros, not present
		dir_tab.push_back(row(mk(OP_DLINK, 12'd0), 1, 64'd0, 0));
		dir_tab.push_back(row(mk(OP_DCHAN, 12'd0), 1, 64'd0, 0));
		// primitive before any header lands on link 0 at time 0
		t = mk(OP_PRIM, 12'd5); t.span_ticks = '1; t.prim_adc_sum = '1; t.prim_adc_peak = '1;
		dir_tab.push_back(row(t));
		dir_tab.push_back(row(mk(OP_DCHAN, 12'd5), 1, 64'd0, 1));
		// max-field header, then a backward sequence step
		t = mk(OP_HDR, 12'd1); t.sequence_number = '1; t.data_time_ticks = '1;
		t.created_us = '1; t.received_us = '0; t.set_total_adc = '1; t.set_bytes = '1;
		t.primitive_count = '1;
		dir_tab.push_back(row(t));
		t.sequence_number = 32'd3; t.received_us = '1; t.created_us = '0;
		t.data_time_ticks = '0;
		dir_tab.push_back(row(t));
		t.sequence_number = 32'd4;
		dir_tab.push_back(row(t));
		t = mk(OP_PRIM, 12'd4095); t.prim_adc_sum = '1;
		dir_tab.push_back(row(t));
		dir_tab.push_back(row(mk(OP_DLINK, 12'd1), 1, 64'd3, 1));
		dir_tab.push_back(row(mk(OP_DCHAN, 12'd4095)));
		// out-of-range header is ignored; prims stay on link 1
		t = mk(OP_HDR, 12'd4095); t.sequence_number = '1;
		dir_tab.push_back(row(t));
		t = mk(OP_PRIM, 12'd7); t.prim_adc_sum = 32'd9;
		dir_tab.push_back(row(t));
		dir_tab.push_back(row(mk(OP_DLINK, 12'd1), 1, 64'd0, 0));
		dir_tab.push_back(row(mk(OP_DLINK, 12'd4095), 1, 64'd0, 0));
		dir_tab.push_back(row(mk(OP_DLINK, 12'd63), 1, 64'd0, 0));
		// channel clears leave the seen bit that channel 5 set on link 0
		dir_tab.push_back(row(mk(OP_DCHAN, 12'd7)));
		dir_tab.push_back(row(mk(OP_DLINK, 12'd0)));

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].it);
			if (dir_tab[i].has_lit) begin
				e = pending_words[pending_words.size() - (dir_tab[i].it.opcode == OP_DLINK
					? LINK_OUT : CHAN_WORDS)];
				if (e.val !== dir_tab[i].lit0 || e.present !== dir_tab[i].lit_present)
					report_mismatch($sformatf("directed row %0d word 0", i),
						e.val, dir_tab[i].lit0);
			end
		end
		wait_idle();

		// phases across register settings and idle patterns
		write_reg(REG_TPU, 53'd1023); write_reg(REG_EPOCH, '1);
		send_idle_pct = 0; stall_pct = 0;
		random_phase(70);
		wait_idle();

		write_reg(REG_TPU, 53'd0); write_reg(REG_EPOCH, 53'd0);
		send_idle_pct = 79; stall_pct = 0;
		random_phase(50);
		wait_idle();

		write_reg(REG_TPU, 53'($urandom_range(2, 50))); write_reg(REG_EPOCH, 53'($urandom));
		send_idle_pct = 0; stall_pct = 79;
		random_phase(50);
		// long receiver hold-off while the sender keeps offering dumps
		hold_off = 600;
		for (int i = 0; i < 8; i++) send_item(rand_item(OP_DCHAN, $urandom_range(31)));
		wait_idle();

		write_reg(REG_TPU, 53'd1); write_reg(REG_EPOCH, 53'd1000);
		send_idle_pct = 36; stall_pct = 36;
		random_phase(50);
		wait_idle();

		send_idle_pct = 0; stall_pct = 0;
		for (int k = 0; k < 8; k++) send_item(rand_item(OP_DLINK, k));
		for (int k = 0; k < 32; k++) send_item(rand_item(OP_DCHAN, k));
		wait_idle();

		$display("Sent %0d items over five idle/config phases; checked %0d dump words.",
			items_sent, words_seen);
		if (fail_count == 0 && pending_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
